/* sv/otl_pkg.sv */
// shared types and codes of the ordered timer list
`default_nettype none

package otl_pkg;

    localparam int OP_W     = 2;
    localparam int ACT_W    = 16;
    localparam int DLY_W    = 31;
    localparam int REM_W    = 33;
    localparam int STATUS_W = 3;

    // request operations
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

    // one stored timer
    typedef struct packed {
        logic signed [ACT_W-1:0] action;
        logic signed [REM_W-1:0] remaining;
        logic [DLY_W-1:0]        period;
        logic                    rep;
    } timer_rec_t;

endpackage

`default_nettype wire

/* sv/otl_req_if.sv */
// request channel of the ordered timer list
`default_nettype none

interface otl_req_if;
    import otl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [ACT_W-1:0] action_code;
    logic [DLY_W-1:0]        delay;
    logic                    repeat_req;
    logic [DLY_W-1:0]        elapsed;

    modport source (output valid, operation, action_code, delay, repeat_req, elapsed,
                    input ready);
    modport sink (input valid, operation, action_code, delay, repeat_req, elapsed,
                  output ready);
endinterface

`default_nettype wire

/* sv/otl_rsp_if.sv */
// result channel of the ordered timer list
`default_nettype none

interface otl_rsp_if;
    import otl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [ACT_W-1:0] fired_action;
    logic                    last;

    modport source (output valid, status, fired_action, last, input ready);
    modport sink (input valid, status, fired_action, last, output ready);
endinterface

`default_nettype wire

/* sv/ordered_timer_list.sv */
// ordered timer list: timer records in a circular memory walked on tick
//
// usage
// - req channel carries add, clear and tick requests; rsp channel carries results
// - every add, clear or tick request gives one or more results, the final one marked by last
// - an add or a clear is accepted, then executed and its result loaded
// - a tick: accept, first read, one timer per cycle while not stalled, then the
//   closing result; the single read port of the timer memory walks the list
// - a firing result is held back one step so that its last flag is known
// - only one request is in the block at a time; ready is high while idle
// - the result register lets the block go on while a result waits to be taken;
//   when the receiver stalls and another result is due, the walk holds in place
// - reset empties the list; memory contents are left as they are and are never
//   read before being written
`default_nettype none

module ordered_timer_list #(
    parameter int TIMER_SLOTS = 16
) (
    input  wire       clk,
    input  wire       rst_n,
    otl_req_if.sink   req,
    otl_rsp_if.source rsp
);
    import otl_pkg::*;

    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int SW = CW + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);
    localparam logic [CW-1:0] SLOTS_C  = CW'(TIMER_SLOTS);
    localparam logic [SW-1:0] SLOTS_S  = SW'(TIMER_SLOTS);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_WALK   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    // circular buffer index step
    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] a);
        return (a == LAST_IDX) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] a);
        return (a == '0) ? LAST_IDX : a - 1'b1;
    endfunction

    // control state
    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] rd_addr_reg, rd_addr_next;
    logic [CW-1:0] rd_left_reg, rd_left_next;
    logic [IW-1:0] wr_addr_reg, wr_addr_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // payload registers
    logic [OP_W-1:0]         cmd_op_reg, cmd_op_next;
    logic signed [ACT_W-1:0] cmd_action_reg, cmd_action_next;
    logic [DLY_W-1:0]        cmd_delay_reg, cmd_delay_next;
    logic                    cmd_repeat_reg, cmd_repeat_next;
    logic [DLY_W-1:0]        cmd_elapsed_reg, cmd_elapsed_next;
    logic signed [ACT_W-1:0] pend_action_reg, pend_action_next;
    logic [STATUS_W-1:0]     rsp_status_reg, rsp_status_next;
    logic signed [ACT_W-1:0] rsp_action_reg, rsp_action_next;
    logic                    rsp_last_reg, rsp_last_next;

    // timer memory, one record per entry, read data registered
    timer_rec_t timer_mem [TIMER_SLOTS];
    timer_rec_t rd_data_reg;
    logic       mem_we;
    logic [IW-1:0] mem_waddr;
    timer_rec_t mem_wdata;
    logic       mem_re;
    logic [IW-1:0] mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            timer_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= timer_mem[mem_raddr];
        end
    end

    // per-entry tick arithmetic
    logic signed [REM_W:0]   diff;
    logic signed [REM_W-1:0] rem_sat;
    logic signed [REM_W-1:0] rem_new;
    logic                    fires;
    logic                    keep;
    logic                    out_free;
    logic                    can_step;
    logic [SW-1:0]           tail_sum;
    logic [SW-1:0]           tail_wrap;
    logic [IW-1:0]           tail_addr;

    always_comb
    begin
        diff = {rd_data_reg.remaining[REM_W-1], rd_data_reg.remaining}
               - $signed({{(REM_W + 1 - DLY_W){1'b0}}, cmd_elapsed_reg});
        // floor at -2^32: top two bits 10 means below the floor
        if (diff[REM_W:REM_W-1] == 2'b10)
        begin
            rem_sat = {1'b1, {(REM_W - 1){1'b0}}};
        end
        else
        begin
            rem_sat = diff[REM_W-1:0];
        end
        fires   = rem_sat[REM_W-1];
        rem_new = fires ? rem_sat + $signed({{(REM_W - DLY_W){1'b0}}, rd_data_reg.period})
                        : rem_sat;
        keep    = !fires || rd_data_reg.rep;
    end

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign can_step  = !fires || !pend_valid_reg || out_free;
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_wrap = (tail_sum >= SLOTS_S) ? tail_sum - SLOTS_S : tail_sum;
    assign tail_addr = tail_wrap[IW-1:0];

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        rd_addr_next     = rd_addr_reg;
        rd_left_next     = rd_left_reg;
        wr_addr_next     = wr_addr_reg;
        kept_next        = kept_reg;
        pend_valid_next  = pend_valid_reg;
        pend_action_next = pend_action_reg;
        cmd_op_next      = cmd_op_reg;
        cmd_action_next  = cmd_action_reg;
        cmd_delay_next   = cmd_delay_reg;
        cmd_repeat_next  = cmd_repeat_reg;
        cmd_elapsed_next = cmd_elapsed_reg;
        rsp_valid_next   = rsp.ready ? 1'b0 : rsp_valid_reg;
        rsp_status_next  = rsp_status_reg;
        rsp_action_next  = rsp_action_reg;
        rsp_last_next    = rsp_last_reg;
        mem_we           = 1'b0;
        mem_waddr        = wr_addr_reg;
        mem_wdata        = '{action: rd_data_reg.action, remaining: rem_new,
                             period: rd_data_reg.period, rep: rd_data_reg.rep};
        mem_re           = 1'b0;
        mem_raddr        = rd_addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_op_next      = req.operation;
                    cmd_action_next  = req.action_code;
                    cmd_delay_next   = req.delay;
                    cmd_repeat_next  = req.repeat_req;
                    cmd_elapsed_next = req.elapsed;
                    state_next       = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (cmd_op_reg)
                    OP_ADD:
                    begin
                        if (out_free)
                        begin
                            rsp_valid_next  = 1'b1;
                            rsp_action_next = '0;
                            rsp_last_next   = 1'b1;
                            if (count_reg == SLOTS_C)
                            begin
                                rsp_status_next = ST_FULL;
                            end
                            else
                            begin
                                rsp_status_next = ST_ADDED;
                                mem_we    = 1'b1;
                                mem_wdata = '{action: cmd_action_reg,
                                              remaining: $signed({2'b00, cmd_delay_reg}),
                                              period: cmd_delay_reg, rep: cmd_repeat_reg};
                                // nonzero delay joins the head, zero delay the tail
                                if (cmd_delay_reg != '0)
                                begin
                                    head_next = idx_dec(head_reg);
                                    mem_waddr = idx_dec(head_reg);
                                end
                                else
                                begin
                                    mem_waddr = tail_addr;
                                end
                                count_next = count_reg + 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    OP_CLEAR:
                    begin
                        if (out_free)
                        begin
                            count_next      = '0;
                            rsp_valid_next  = 1'b1;
                            rsp_status_next = ST_CLEARED;
                            rsp_action_next = '0;
                            rsp_last_next   = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    OP_TICK:
                    begin
                        pend_valid_next = 1'b0;
                        wr_addr_next    = head_reg;
                        kept_next       = '0;
                        if (count_reg == '0)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            mem_re       = 1'b1;
                            mem_raddr    = head_reg;
                            rd_addr_next = idx_inc(head_reg);
                            rd_left_next = count_reg - 1'b1;
                            state_next   = S_WALK;
                        end
                    end
                    default:
                    begin
                        // unused operation: no result
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WALK:
            begin
                if (can_step)
                begin
                    // survivors are packed back from the head in list order
                    if (keep)
                    begin
                        mem_we       = 1'b1;
                        wr_addr_next = idx_inc(wr_addr_reg);
                        kept_next    = kept_reg + 1'b1;
                    end
                    if (fires)
                    begin
                        if (pend_valid_reg)
                        begin
                            rsp_valid_next  = 1'b1;
                            rsp_status_next = ST_FIRED;
                            rsp_action_next = pend_action_reg;
                            rsp_last_next   = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_action_next = rd_data_reg.action;
                    end
                    if (rd_left_reg != '0)
                    begin
                        mem_re       = 1'b1;
                        rd_addr_next = idx_inc(rd_addr_reg);
                        rd_left_next = rd_left_reg - 1'b1;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_last_next   = 1'b1;
                    if (pend_valid_reg)
                    begin
                        rsp_status_next = ST_FIRED;
                        rsp_action_next = pend_action_reg;
                    end
                    else
                    begin
                        rsp_status_next = ST_NONE;
                        rsp_action_next = '0;
                    end
                    count_next      = kept_reg;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            rd_addr_reg    <= '0;
            rd_left_reg    <= '0;
            wr_addr_reg    <= '0;
            kept_reg       <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            rd_addr_reg    <= rd_addr_next;
            rd_left_reg    <= rd_left_next;
            wr_addr_reg    <= wr_addr_next;
            kept_reg       <= kept_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_op_reg      <= cmd_op_next;
        cmd_action_reg  <= cmd_action_next;
        cmd_delay_reg   <= cmd_delay_next;
        cmd_repeat_reg  <= cmd_repeat_next;
        cmd_elapsed_reg <= cmd_elapsed_next;
        pend_action_reg <= pend_action_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_action_reg  <= rsp_action_next;
        rsp_last_reg    <= rsp_last_next;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.fired_action = rsp_action_reg;
    assign rsp.last         = rsp_last_reg;

    // list never holds more timers than slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOTS_C)
        else $error("timer count above slot count");

    // survivors of a walk never outnumber the list it started from
    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK || state_reg == S_FINISH) |-> kept_reg <= count_reg)
        else $error("kept count above list count");

    // held firing never outlives its tick
    a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("held firing left after tick");

    // only firing results carry an action
    a_action_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_status_reg != ST_FIRED) |-> rsp_action_reg == '0)
        else $error("action on a non-firing result");

    // the walk writes only where it has already read
    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && mem_we) |-> kept_reg < count_reg)
        else $error("walk write beyond its read position");

endmodule

`default_nettype wire
